[src/sspq_pkg.sv]
`default_nettype none
package sspq_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int DATA_W           = 32;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PEEK    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic              enq;
    logic              deq;
    logic [DATA_W-1:0] pri;
    logic [DATA_W-1:0] pay;
  } cell_cmd_t;

endpackage
`default_nettype wire

[src/sspq_cell.sv]
`default_nettype none
module sspq_cell import sspq_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire logic              clk,
  input  wire cell_cmd_t         cmd,
  input  wire logic [CNT_W-1:0]  count,
  input  wire logic              left_place,
  input  wire logic [DATA_W-1:0] left_pay,
  input  wire logic [DATA_W-1:0] left_pri,
  input  wire logic [DATA_W-1:0] right_pay,
  input  wire logic [DATA_W-1:0] right_pri,
  output logic                   place,
  output logic [DATA_W-1:0]      pay,
  output logic [DATA_W-1:0]      pri
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic occupied;
  logic greater;

  // A cell is at or behind the insertion point when it is empty or holds a
  // strictly larger priority; equal priorities stay ahead of the new entry.
  assign occupied = count > IDX_C;
  assign greater  = $signed(pri) > $signed(cmd.pri);
  assign place    = !occupied || greater;

  always_ff @(posedge clk) begin
    if (cmd.enq && place) begin
      if (left_place) begin
        pay <= left_pay;
        pri <= left_pri;
      end else begin
        pay <= cmd.pay;
        pri <= cmd.pri;
      end
    end else if (cmd.deq) begin
      pay <= right_pay;
      pri <= right_pri;
    end
  end

endmodule
`default_nettype wire

[src/stable_sorted_priority_queue.sv]
`default_nettype none
// Stable sorted priority queue built as a chain of CAPACITY cells.
// Input channel (in_valid / in_stall) carries one operation per transaction:
// enqueue payload with signed priority_req, dequeue the front entry, or peek
// it. Smallest priority is served first; equal priorities leave in arrival
// order. Operation code 3 does nothing and reports done.
// Output channel (out_valid / out_stall) returns one result per transaction:
// front payload and priority (zero unless an entry was removed or peeked),
// a status code, and empty / full flags after the operation.
// The result is registered in the output register in the cycle after the
// input transaction. One transaction per cycle is accepted while the receiver
// does not stall; every cell compares against the new priority and shifts
// together, so the cell chain sets no limit beyond the output register.
// When the receiver stalls, the result holds in the output register and
// in_stall rises, so no new transaction enters until the result is taken.
// Reset clears the entry count and the output valid; cell contents are not
// cleared, since only entries below the count are ever read.
module stable_sorted_priority_queue import sspq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] payload,
  input  wire logic signed [31:0] priority_req,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      front_payload,
  output logic signed [31:0] front_priority,
  output logic [1:0]       status,
  output logic             empty_after,
  output logic             full_after
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic             accept;
  logic             is_empty;
  logic             is_full;
  logic             enq_ok;
  logic             deq_ok;
  logic             take_front;
  status_t          status_next;
  cell_cmd_t        cmd;

  logic [CAPACITY:0]  place_chain;
  logic [DATA_W-1:0]  cell_pay [CAPACITY];
  logic [DATA_W-1:0]  cell_pri [CAPACITY];

  // Hold the input while a finished result waits at a stalled receiver.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_empty = count == '0;
  assign is_full  = count == CAP_C;

  always_comb begin
    enq_ok      = 1'b0;
    deq_ok      = 1'b0;
    take_front  = 1'b0;
    status_next = ST_DONE;
    unique case (op_t'(operation))
      OP_ENQUEUE: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          enq_ok = accept;
        end
      end
      OP_DEQUEUE: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          deq_ok     = accept;
          take_front = 1'b1;
        end
      end
      OP_PEEK: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          take_front = 1'b1;
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  always_comb begin
    priority if (enq_ok) begin
      count_next = count + 1'b1;
    end else if (deq_ok) begin
      count_next = count - 1'b1;
    end else begin
      count_next = count;
    end
  end

  assign cmd.enq = enq_ok;
  assign cmd.deq = deq_ok;
  assign cmd.pri = priority_req;
  assign cmd.pay = payload;

  // Nothing ahead of the front cell, so it never takes a left neighbor.
  assign place_chain[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] l_pay, l_pri, r_pay, r_pri;

    if (i == 0) begin : g_first
      assign l_pay = '0;
      assign l_pri = '0;
    end else begin : g_mid
      assign l_pay = cell_pay[i-1];
      assign l_pri = cell_pri[i-1];
    end

    // The last cell has no right neighbor; after a dequeue it is unused.
    if (i == CAPACITY - 1) begin : g_last
      assign r_pay = cell_pay[i];
      assign r_pri = cell_pri[i];
    end else begin : g_inner
      assign r_pay = cell_pay[i+1];
      assign r_pri = cell_pri[i+1];
    end

    sspq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count),
      .left_place (place_chain[i]),
      .left_pay   (l_pay),
      .left_pri   (l_pri),
      .right_pay  (r_pay),
      .right_pri  (r_pri),
      .place      (place_chain[i+1]),
      .pay        (cell_pay[i]),
      .pri        (cell_pri[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Output register: advance on every accepted transaction, drop valid once
  // the receiver takes the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_payload  <= take_front ? cell_pay[0] : '0;
      front_priority <= take_front ? $signed(cell_pri[0]) : '0;
      status         <= status_next;
      empty_after    <= count_next == '0;
      full_after     <= count_next == CAP_C;
    end
  end

endmodule
`default_nettype wire
